>>> design/nkud_pkg.sv
// Shared codes and the result word type for the NAL key unit detector.
// No dependencies; used by nkud_parse and nal_key_unit_detector_core.
package nkud_pkg;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSTART  = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_THREE = 2'd1;
  localparam logic [1:0] KIND_FOUR  = 2'd2;

  localparam logic [1:0] PH_ZEROS  = 2'd0;
  localparam logic [1:0] PH_SUFFIX = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  localparam logic [2:0] HC_ZERO0 = 3'd0;
  localparam logic [2:0] HC_ZERO1 = 3'd1;
  localparam logic [2:0] HC_THIRD = 3'd2;
  localparam logic [2:0] HC_FOURTH = 3'd3;
  localparam logic [2:0] HC_HEADER = 3'd4;
  localparam logic [2:0] HC_BODY  = 3'd5;

  localparam logic [4:0] TYPE_SLICE = 5'd1;
  localparam logic [4:0] TYPE_SPS   = 5'd7;
  localparam logic [4:0] TYPE_MASK  = 5'h1F;
  localparam logic [4:0] SLICE_SAT  = 5'd31;

  localparam logic [4:0] SLICE_I      = 5'd2;
  localparam logic [4:0] SLICE_SI     = 5'd4;
  localparam logic [4:0] SLICE_I_ALL  = 5'd7;
  localparam logic [4:0] SLICE_SI_ALL = 5'd9;

  typedef struct packed {
    logic [1:0] start_kind;
    logic [4:0] nal_type;
    logic [4:0] slice_code;
    logic       slice_valid;
    logic       key_unit;
    logic [1:0] status;
  } result_t;

endpackage

>>> design/nkud_parse.sv
// Start code, NAL header and Exp-Golomb slice type parser state.
// Handles one byte per fire, eight bit steps per byte. Uses nkud_pkg.
module nkud_parse #(
  parameter int ZERO_RUN_LIMIT = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        nal_byte,
  input  logic              last_byte,
  output nkud_pkg::result_t result
);

  localparam int ZW = $clog2(ZERO_RUN_LIMIT + 1);

  logic [2:0]    header_count, header_count_next;
  logic [1:0]    start_seen, start_seen_next;
  logic [4:0]    type_held, type_held_next;
  logic [1:0]    golomb_phase, golomb_phase_next;
  logic          code_index, code_index_next;
  logic [ZW-1:0] zero_run, zero_run_next;
  logic [ZW-1:0] suffix_left, suffix_left_next;
  logic [4:0]    suffix_accum, suffix_accum_next;
  logic [4:0]    slice_held, slice_held_next;
  logic [1:0]    error_held, error_held_next;

  logic          bit_val;
  logic          finish;
  logic [4:0]    run5;
  logic [5:0]    code_val;
  logic [1:0]    status;
  logic [4:0]    ntype;
  logic [4:0]    scode;

  always_comb begin
    header_count_next = header_count;
    start_seen_next   = start_seen;
    type_held_next    = type_held;
    golomb_phase_next = golomb_phase;
    code_index_next   = code_index;
    zero_run_next     = zero_run;
    suffix_left_next  = suffix_left;
    suffix_accum_next = suffix_accum;
    slice_held_next   = slice_held;
    error_held_next   = error_held;
    bit_val           = 1'b0;
    finish            = 1'b0;
    run5              = '0;
    code_val          = '0;
    if (error_held == nkud_pkg::ST_OK) begin
      unique case (header_count) inside
        nkud_pkg::HC_ZERO0, nkud_pkg::HC_ZERO1: begin
          if (nal_byte != 8'h00) error_held_next = nkud_pkg::ST_NOSTART;
          else header_count_next = header_count + 3'd1;
        end
        nkud_pkg::HC_THIRD: begin
          if (nal_byte == 8'h01) begin
            start_seen_next   = nkud_pkg::KIND_THREE;
            header_count_next = nkud_pkg::HC_FOURTH;
          end else if (nal_byte == 8'h00) begin
            header_count_next = nkud_pkg::HC_FOURTH;
          end else begin
            error_held_next = nkud_pkg::ST_NOSTART;
          end
        end
        nkud_pkg::HC_FOURTH: begin
          if (start_seen == nkud_pkg::KIND_THREE) begin
            type_held_next    = nal_byte[4:0] & nkud_pkg::TYPE_MASK;
            header_count_next = nkud_pkg::HC_BODY;
          end else if (nal_byte == 8'h01) begin
            start_seen_next   = nkud_pkg::KIND_FOUR;
            header_count_next = nkud_pkg::HC_HEADER;
          end else begin
            error_held_next = nkud_pkg::ST_NOSTART;
          end
        end
        nkud_pkg::HC_HEADER: begin
          type_held_next    = nal_byte[4:0] & nkud_pkg::TYPE_MASK;
          header_count_next = nkud_pkg::HC_BODY;
        end
        default: begin
          if (type_held == nkud_pkg::TYPE_SLICE) begin
            for (int i = 0; i < 8; i++) begin
              if (golomb_phase_next != nkud_pkg::PH_DONE &&
                  error_held_next == nkud_pkg::ST_OK) begin
                bit_val = nal_byte[7-i];
                finish  = 1'b0;
                if (golomb_phase_next == nkud_pkg::PH_ZEROS) begin
                  if (!bit_val) begin
                    if (zero_run_next >= ZW'(ZERO_RUN_LIMIT))
                      error_held_next = nkud_pkg::ST_OVERFLOW;
                    else
                      zero_run_next = ZW'(zero_run_next + 1'b1);
                  end else if (zero_run_next == '0) begin
                    suffix_accum_next = '0;
                    finish            = 1'b1;
                  end else begin
                    golomb_phase_next = nkud_pkg::PH_SUFFIX;
                    suffix_left_next  = zero_run_next;
                    suffix_accum_next = '0;
                  end
                end else begin
                  suffix_accum_next = {suffix_accum_next[3:0], bit_val};
                  suffix_left_next  = ZW'(suffix_left_next - 1'b1);
                  if (suffix_left_next == '0) finish = 1'b1;
                end
                if (finish) begin
                  if (!code_index_next) begin
                    code_index_next   = 1'b1;
                    golomb_phase_next = nkud_pkg::PH_ZEROS;
                    zero_run_next     = '0;
                    suffix_left_next  = '0;
                    suffix_accum_next = '0;
                  end else begin
                    golomb_phase_next = nkud_pkg::PH_DONE;
                    run5     = 5'(zero_run_next);
                    code_val = (6'd1 << run5[2:0]) - 6'd1 + {1'b0, suffix_accum_next};
                    if (run5 > 5'd5 || code_val > 6'd31) begin
                      slice_held_next = nkud_pkg::SLICE_SAT;
                      error_held_next = nkud_pkg::ST_OVERFLOW;
                    end else begin
                      slice_held_next = code_val[4:0];
                    end
                  end
                end
              end
            end
          end
        end
      endcase
    end
  end

  // result as seen after this byte
  always_comb begin
    status = error_held_next;
    if (status == nkud_pkg::ST_OK) begin
      if (header_count_next != nkud_pkg::HC_BODY)
        status = nkud_pkg::ST_TRUNC;
      else if (type_held_next == nkud_pkg::TYPE_SLICE &&
               golomb_phase_next != nkud_pkg::PH_DONE)
        status = nkud_pkg::ST_TRUNC;
    end
    ntype = (status == nkud_pkg::ST_NOSTART || header_count_next != nkud_pkg::HC_BODY) ?
            5'd0 : type_held_next;
    scode = (ntype == nkud_pkg::TYPE_SLICE && golomb_phase_next == nkud_pkg::PH_DONE) ?
            slice_held_next : 5'd0;
    result.start_kind  = (status == nkud_pkg::ST_NOSTART) ? nkud_pkg::KIND_NONE :
                         start_seen_next;
    result.nal_type    = ntype;
    result.slice_code  = scode;
    result.slice_valid = (status == nkud_pkg::ST_OK && ntype == nkud_pkg::TYPE_SLICE);
    result.key_unit    = (status == nkud_pkg::ST_OK) &&
                         ((ntype == nkud_pkg::TYPE_SPS) ||
                          (ntype == nkud_pkg::TYPE_SLICE &&
                           (scode == nkud_pkg::SLICE_I || scode == nkud_pkg::SLICE_SI ||
                            scode == nkud_pkg::SLICE_I_ALL ||
                            scode == nkud_pkg::SLICE_SI_ALL)));
    result.status      = status;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && last_byte)) begin
      header_count <= nkud_pkg::HC_ZERO0;
      start_seen   <= nkud_pkg::KIND_NONE;
      type_held    <= '0;
      golomb_phase <= nkud_pkg::PH_ZEROS;
      code_index   <= 1'b0;
      zero_run     <= '0;
      suffix_left  <= '0;
      suffix_accum <= '0;
      slice_held   <= '0;
      error_held   <= nkud_pkg::ST_OK;
    end else if (fire) begin
      header_count <= header_count_next;
      start_seen   <= start_seen_next;
      type_held    <= type_held_next;
      golomb_phase <= golomb_phase_next;
      code_index   <= code_index_next;
      zero_run     <= zero_run_next;
      suffix_left  <= suffix_left_next;
      suffix_accum <= suffix_accum_next;
      slice_held   <= slice_held_next;
      error_held   <= error_held_next;
    end
  end

endmodule

>>> design/nal_key_unit_detector_core.sv
// NAL key unit detector top: input word register, parser, result register.
// Depends on nkud_pkg and nkud_parse.
// A last byte's result passes the input word register, then the result register onto m_*.
// Throughput: one byte per cycle; non-last bytes keep flowing while a result waits on
// m_tready, a last byte waits until the result register frees. Per-byte work is the
// eight unrolled bit steps in nkud_parse.
// Reset (rst, synchronous): empties both registers and returns the parser to start-code search.
module nal_key_unit_detector_core #(
  parameter int ZERO_RUN_LIMIT = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] nal_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [4:0] nal_type, [9:5] slice_code, [15:10] zero
  output logic [5:0]  m_tuser    // [1:0] start_kind, [2] slice_valid, [3] key_unit,
                                 // [5:4] status
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_last;
  logic              fire;
  nkud_pkg::result_t res;
  nkud_pkg::result_t out_res;

  assign fire     = s1_valid && (!s1_last || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_byte <= s_tdata;
      s1_last <= s_tlast;
    end
  end

  nkud_parse #(
    .ZERO_RUN_LIMIT(ZERO_RUN_LIMIT)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .nal_byte  (s1_byte),
    .last_byte (s1_last),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && s1_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_last) out_res <= res;
  end

  assign m_tdata = {6'd0, out_res.slice_code, out_res.nal_type};
  assign m_tuser = {out_res.status, out_res.key_unit, out_res.slice_valid,
                    out_res.start_kind};

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    fire && s1_last |=> m_tvalid)
    else $error("result word not presented after last byte");

  a_error_no_key: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.status != nkud_pkg::ST_OK |->
      !out_res.key_unit && !out_res.slice_valid)
    else $error("key or slice_valid set with error status");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !fire |=> s1_valid && $stable(s1_byte) && $stable(s1_last))
    else $error("stalled input word lost");

  a_slice_needs_type: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.slice_code != 5'd0 |-> out_res.nal_type == nkud_pkg::TYPE_SLICE)
    else $error("slice code on non-slice unit");

endmodule
